FILE: rtl/sli_pkg.sv
// ============================================================================
// sli_pkg: shared types for the sorted list insert/remove block
// Status and action codes, and the control group broadcast to the cells.
// ============================================================================
package sli_pkg;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } action_t;

    typedef struct packed {
        logic upd;   // store changes this cycle
        logic rmv;   // shift towards the head (remove) instead of away
    } cell_ctrl_t;

endpackage

FILE: rtl/sli_if.sv
// ============================================================================
// sli_if: request and result channels of the sorted list block
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ============================================================================
interface sli_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface sli_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [4:0]         count;
    logic               head_valid;
    logic signed [31:0] head_value;

    modport source (output valid, output status, output count, output head_valid,
                    output head_value, input ready);
    modport sink   (input valid, input status, input count, input head_valid,
                    input head_value, output ready);
endinterface

FILE: rtl/sorted_list_insert_remove.sv
// ============================================================================
// sorted_list_insert_remove: bounded ascending store with insert and remove
// Row of compare-and-shift cells keeping signed items in sorted order.
// ============================================================================
// Usage:
//   req carries action (0 insert, 1 remove one copy) and a signed value.
//   rsp returns one result per request: status (done, not found, full),
//   the count held afterwards and the smallest item held (zero if empty).
//   Every cell compares itself with the request value in parallel and
//   shifts one place, so a request is completed in the cycle it is taken;
//   its result appears on rsp in the next cycle from an output register.
//   Throughput is one request per cycle while rsp is not stalled.
//   Inserting when full or removing an absent value leaves the store unchanged.
//   Reset empties the store (count zero); slot contents are not cleared.
//   While rsp is stalled with a result held, req.ready is low; a new
//   request is taken in the same cycle that the held result is taken.
// ============================================================================
module sorted_list_insert_remove #(
    parameter int CAPACITY  = 16,
    parameter int ITEM_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    sli_in_if.sink        req,
    sli_out_if.source     rsp
);
    import sli_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [ITEM_BITS-1:0] item_q    [CAPACITY];
    logic [ITEM_BITS-1:0] item_nq   [CAPACITY];
    logic [CAPACITY-1:0]  lt_vec;
    logic [CAPACITY-1:0]  eq_vec;

    logic [63:0]          val_wide;
    logic [ITEM_BITS-1:0] val;
    logic                 accept;
    logic                 rmv;
    logic                 full;
    logic                 found;
    cell_ctrl_t           ctrl;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    status_t              status_reg;
    status_t              status_next;
    logic [4:0]           count_out_reg;
    logic [4:0]           count_out_next;
    logic                 head_valid_reg;
    logic                 head_valid_next;
    logic [31:0]          head_value_reg;
    logic [31:0]          head_value_next;
    logic [31:0]          count_wide;
    logic [63:0]          head_wide;

    assign val_wide = 64'(req.value);
    assign val      = val_wide[ITEM_BITS-1:0];

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign rmv       = (req.action == ACT_REMOVE);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign found     = |eq_vec;

    assign ctrl.rmv = rmv;
    assign ctrl.upd = accept && (rmv ? found : !full);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [ITEM_BITS-1:0] prev_item;
            logic                 prev_lt;
            logic [ITEM_BITS-1:0] next_item;

            if (gi == 0)
            begin : g_first
                assign prev_item = val;
                assign prev_lt   = 1'b1;
            end
            else
            begin : g_mid
                assign prev_item = item_q[gi-1];
                assign prev_lt   = lt_vec[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_item = item_q[gi];
            end
            else
            begin : g_body
                assign next_item = item_q[gi+1];
            end

            sli_cell #(
                .ITEM_BITS (ITEM_BITS),
                .CNT_W     (CNT_W),
                .IDX       (gi)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .val       (val),
                .count     (count_reg),
                .prev_item (prev_item),
                .prev_lt   (prev_lt),
                .next_item (next_item),
                .item      (item_q[gi]),
                .item_nxt  (item_nq[gi]),
                .lt        (lt_vec[gi]),
                .eq        (eq_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        if (!ctrl.upd)
        begin
            count_next = count_reg;
        end
        else if (rmv)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        if (rmv && !found)
        begin
            status_next = ST_NOT_FOUND;
        end
        else if (!rmv && full)
        begin
            status_next = ST_FULL;
        end
        else
        begin
            status_next = ST_DONE;
        end
    end

    assign count_wide      = 32'(count_next);
    assign head_wide       = 64'($signed(item_nq[0]));
    assign count_out_next  = count_wide[4:0];
    assign head_valid_next = (count_next != '0);
    assign head_value_next = head_valid_next ? head_wide[31:0] : 32'd0;
    assign out_valid_next  = accept ? 1'b1 : (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            count_out_reg  <= count_out_next;
            head_valid_reg <= head_valid_next;
            head_value_reg <= head_value_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.count      = count_out_reg;
    assign rsp.head_valid = head_valid_reg;
    assign rsp.head_value = head_value_reg;

    // Count never runs past the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("item count exceeds capacity");

    // A failed request leaves the count as it was.
    a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ((rmv && !found) || (!rmv && full)) |=> count_reg == $past(count_reg))
        else $error("rejected request changed the count");

    // A successful insert grows the store by exactly one.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !rmv && !full |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not add one item");

    // Result head flag agrees with the reported count.
    a_head_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.head_valid == (count_reg != '0)))
        else $error("head flag disagrees with count");

endmodule

FILE: rtl/sli_cell.sv
// ============================================================================
// sli_cell: one slot of the sorted store
// Holds one item, compares it with the request value and takes its own,
// its neighbour's or the request value on each update.
// ============================================================================
module sli_cell #(
    parameter int ITEM_BITS = 32,
    parameter int CNT_W     = 5,
    parameter int IDX       = 0
) (
    input  logic                   clk,
    input  sli_pkg::cell_ctrl_t    ctrl,
    input  logic [ITEM_BITS-1:0]   val,
    input  logic [CNT_W-1:0]       count,
    input  logic [ITEM_BITS-1:0]   prev_item,
    input  logic                   prev_lt,
    input  logic [ITEM_BITS-1:0]   next_item,
    output logic [ITEM_BITS-1:0]   item,
    output logic [ITEM_BITS-1:0]   item_nxt,
    output logic                   lt,
    output logic                   eq
);
    import sli_pkg::*;

    logic [ITEM_BITS-1:0] item_reg;
    logic [ITEM_BITS-1:0] item_next;
    logic                 occupied;

    assign occupied = CNT_W'(IDX) < count;
    assign lt       = occupied && ($signed(item_reg) < $signed(val));
    assign eq       = occupied && (item_reg == val);

    always_comb
    begin
        if (!ctrl.upd || lt)
        begin
            item_next = item_reg;
        end
        else if (ctrl.rmv)
        begin
            item_next = next_item;
        end
        else if (prev_lt)
        begin
            item_next = val;
        end
        else
        begin
            item_next = prev_item;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item     = item_reg;
    assign item_nxt = item_next;

endmodule
